### src/stereo_lfo_modulated_delay_defines.svh
// assertion macros for the stereo modulated delay
// no dependencies
`ifndef STEREO_LFO_MODULATED_DELAY_DEFINES_SVH
`define STEREO_LFO_MODULATED_DELAY_DEFINES_SVH
// implication checked every clock outside reset
`define SLMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next cycle implication checked outside reset
`define SLMD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### src/slmd_pkg.sv
// shared types, constants and sine table function for the stereo modulated delay
// no dependencies
package slmd_pkg;
   localparam int CfgIdxWidth = 3;
   localparam logic [CfgIdxWidth-1:0] REG_AMOUNT_TARGET = 3'd0;
   localparam logic [CfgIdxWidth-1:0] REG_SMOOTHING_COEF = 3'd1;
   localparam logic [CfgIdxWidth-1:0] REG_RATE_LEFT = 3'd2;
   localparam logic [CfgIdxWidth-1:0] REG_RATE_RIGHT = 3'd3;
   localparam logic [CfgIdxWidth-1:0] REG_CENTER_DELAY = 3'd4;
   localparam logic [CfgIdxWidth-1:0] REG_SWING_DEPTH = 3'd5;
   localparam int CfgDataWidth = 24;
   localparam int SineDepthMax = 4096;
   localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
   localparam logic [24:0] FullQ24 = 25'd16777216;
   localparam logic [24:0] EpsQ24 = 25'd167;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SMOOTH,
      ST_DELAY,
      ST_ADDR,
      ST_READ,
      ST_MIX,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic bypass_chk;
      logic write_line;
      logic smooth;
      logic delay;
      logic addr;
      logic mix;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic bypass;
   } status_type;

   // quarter-wave sine, Q1.15, entry i of a table of depth n (n a power of two)
   // series terms divided by (2k)(2k+1) through reciprocals scaled by 2^41 and rounded up
   function automatic logic [15:0] sine_entry(input int i, input int n);
      longint unsigned x, x2, term;
      longint sum, q;
      logic [63:0]  recip;
      logic [127:0] wide;
      x = (longint'(HalfPiQ30) * longint'(i)) >> $clog2(n);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      q = 0;
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         case (k)
            1:       recip = 64'd366503875926;
            2:       recip = 64'd109951162778;
            3:       recip = 64'd52357696561;
            4:       recip = 64'd30541989661;
            5:       recip = 64'd19991120506;
            6:       recip = 64'd14096302921;
            default: recip = 64'd10471539313;
         endcase
         wide = 128'(term) * 128'(recip);
         term = wide[104:41];
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum > 0) q = (sum + 16384) >>> 15;
      if (q > 32767) q = 32767;
      return q[15:0];
   endfunction
endpackage

### src/stereo_lfo_modulated_delay.sv
// stereo modulated delay: one word in flight,
// next word accepted once the result is taken
// bypassed words: smoother step, then straight to the output step
// stages: smoother, delay multiply, address, two ram reads, interpolation
// synchronous active-high reset: phases, amount, write index, fill count
// and registers return to defaults; no clearing pass (fill count masks lines)
`include "stereo_lfo_modulated_delay_defines.svh"
module stereo_lfo_modulated_delay import slmd_pkg::*; #(
   parameter int DELAY_DEPTH = 1024,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_in_left,
   input  logic signed [SAMPLE_WIDTH-1:0] req_in_right,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_left,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_right,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CfgIdxWidth-1:0]         csr_index,
   input  logic [CfgDataWidth-1:0]        csr_data
);
   cmd_type    cmd;
   status_type status;
   logic       clearing;

   // configuration registers
   logic [16:0] amt_goal_ff;
   logic [23:0] smoothing_coef_ff;
   logic [19:0] rate_left_ff, rate_right_ff;
   logic [9:0]  center_delay_ff, swing_depth_ff;

   assign csr_ready = !clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         amt_goal_ff <= '0;
         smoothing_coef_ff <= 24'd11645;
         rate_left_ff <= 20'd6263;
         rate_right_ff <= 20'd7427;
         center_delay_ff <= 10'd404;
         swing_depth_ff <= 10'd380;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_AMOUNT_TARGET:  amt_goal_ff <= csr_data[16:0];
            REG_SMOOTHING_COEF: smoothing_coef_ff <= csr_data[23:0];
            REG_RATE_LEFT:      rate_left_ff <= csr_data[19:0];
            REG_RATE_RIGHT:     rate_right_ff <= csr_data[19:0];
            REG_CENTER_DELAY:   center_delay_ff <= csr_data[9:0];
            REG_SWING_DEPTH:    swing_depth_ff <= csr_data[9:0];
            default:            ;
         endcase
      end
   end

   // sequencer
   slmd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd), .clearing(clearing));

   // lines, lfos, smoother and interpolator
   slmd_dp #(
      .DELAY_DEPTH(DELAY_DEPTH), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_left(req_in_left), .in_right(req_in_right),
      .amt_goal(amt_goal_ff), .smoothing_coef(smoothing_coef_ff),
      .rate_left(rate_left_ff), .rate_right(rate_right_ff),
      .center_delay(center_delay_ff), .swing_depth(swing_depth_ff),
      .out_left(rsp_out_left), .out_right(rsp_out_right));

   // no new word while a result waits
   `SLMD_ASSERT_IMP(a_no_accept_while_full, clock, reset, rsp_valid, !req_ready)
   // a result not taken stays valid
   `SLMD_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

### src/slmd_ram.sv
// generic single write, single read ram with registered read
// no dependencies
module slmd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### src/slmd_ctrl.sv
// sequencer for one stereo word: bypass check, write, smooth, delay, read, mix
// depends on slmd_pkg
module slmd_ctrl import slmd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd,
   output logic       clearing
);
   // no clearing pass: unwritten line entries are masked by the datapath fill count
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign clearing = 1'b0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid && !rsp_valid_ff) state_in = ST_SMOOTH;
         ST_SMOOTH: state_in = status.bypass ? ST_OUT : ST_DELAY;
         ST_DELAY:  state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_READ;
         ST_READ:   state_in = ST_MIX;
         ST_MIX:    state_in = ST_OUT;
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
      case (state_ff)
         ST_IDLE:   cmd.bypass_chk = req_valid && !rsp_valid_ff;
         ST_SMOOTH: begin
            cmd.smooth = !status.bypass;
            cmd.write_line = !status.bypass;
         end
         ST_DELAY:  cmd.delay = 1'b1;
         ST_ADDR:   cmd.addr = 1'b1;
         ST_MIX:    cmd.mix = 1'b1;
         ST_OUT:    cmd.commit = 1'b1;
         default:   ;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_OUT) rsp_valid_in = 1'b1;
   end
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### src/slmd_dp.sv
// datapath: delay lines, lfo phases, amount smoother, interpolator
// depends on slmd_pkg and slmd_ram
module slmd_dp import slmd_pkg::*; #(
   parameter int DELAY_DEPTH = 1024,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic signed [SAMPLE_WIDTH-1:0] in_left,
   input  logic signed [SAMPLE_WIDTH-1:0] in_right,
   input  logic [16:0]                    amt_goal,
   input  logic [23:0]                    smoothing_coef,
   input  logic [19:0]                    rate_left,
   input  logic [19:0]                    rate_right,
   input  logic [9:0]                     center_delay,
   input  logic [9:0]                     swing_depth,
   output logic signed [SAMPLE_WIDTH-1:0] out_left,
   output logic signed [SAMPLE_WIDTH-1:0] out_right
);
   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int SW = $clog2(SINE_TABLE_DEPTH);
   localparam int DW = AW + 8;
   localparam logic [DW-1:0] Lim = DW'((DELAY_DEPTH - 2) * 256);
   localparam logic [SW:0] SDepth = (SW+1)'(SINE_TABLE_DEPTH);

   // line contents are not cleared at reset: entries not yet written read as
   // zero through a fill count (writes go in index order from zero)
   logic [AW:0] fill_ff, fill_in;
   logic [AW-1:0] widx_ff;
   logic [31:0] lph_ff, rph_ff;
   logic [24:0] sm_ff, sm_in;
   logic        byp_ff;
   logic signed [SAMPLE_WIDTH-1:0] xl_ff, xr_ff, ol_ff, or_ff;
   logic [DW-1:0] dl_ff, dr_ff;
   logic [7:0] gl_ff, gr_ff;
   logic v0l_ff, v1l_ff, v0r_ff, v1r_ff;
   logic [1:0] rd_ph_ff;
   logic signed [SAMPLE_WIDTH-1:0] b1l_ff, b1r_ff;
   logic [AW-1:0] i0l_ff, i0r_ff;

   logic [15:0] stab [SINE_TABLE_DEPTH+1];
   always_comb for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
      stab[i] = sine_entry(i, SINE_TABLE_DEPTH);

   logic [16:0] tgt;
   assign tgt = (amt_goal > 17'd65536) ? 17'd65536 : amt_goal;
   assign status.bypass = byp_ff;

   // smoother
   logic signed [26:0] diff;
   logic signed [51:0] prod;
   logic signed [26:0] smn;
   assign diff = $signed({2'b0, tgt, 8'b0}) - $signed({2'b0, sm_ff});
   assign prod = $signed({1'b0, smoothing_coef}) * diff;
   assign smn = $signed({2'b0, sm_ff}) + 27'(prod >>> 24);

   // sine lookups
   function automatic logic signed [16:0] sin_lookup(input logic [31:0] ph,
         input logic [15:0] a, input logic [15:0] b);
      logic [15:0] v;
      v = ph[30] ? b : a;
      return ph[31] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction
   logic [SW-1:0] lidx, ridx;
   assign lidx = lph_ff[29 -: SW];
   assign ridx = rph_ff[29 -: SW];
   logic signed [16:0] sl, sr;
   assign sl = sin_lookup(lph_ff, stab[lidx], stab[SDepth - {1'b0, lidx}]);
   assign sr = sin_lookup(rph_ff, stab[ridx], stab[SDepth - {1'b0, ridx}]);

   // modulated delay in q15 samples
   logic signed [27:0] ml, mr;
   assign ml = $signed({3'b0, center_delay, 15'b0}) + $signed({1'b0, swing_depth}) * sl;
   assign mr = $signed({3'b0, center_delay, 15'b0}) + $signed({1'b0, swing_depth}) * sr;
   logic signed [27:0] ml_ff, mr_ff;

   function automatic logic [DW-1:0] sat_delay(input logic [24:0] s,
         input logic signed [27:0] m);
      logic [52:0] p;
      logic [52:0] d;
      p = (m > 0) ? 53'(s) * 53'(m[26:0]) : 53'd0;
      d = p >> 31;
      return (d > 53'(Lim)) ? Lim : d[DW-1:0];
   endfunction

   logic [DW-1:0] dln, drn;
   assign dln = sat_delay(sm_ff, ml_ff);
   assign drn = sat_delay(sm_ff, mr_ff);

   // newer sample is addressed straight from the delay during the address step
   logic [AW-1:0] ram_ra_l, ram_ra_r;
   logic signed [SAMPLE_WIDTH-1:0] rdl, rdr;
   assign ram_ra_l = (rd_ph_ff == 2'd0) ? AW'(widx_ff - dl_ff[DW-1:8]) : i0l_ff;
   assign ram_ra_r = (rd_ph_ff == 2'd0) ? AW'(widx_ff - dr_ff[DW-1:8]) : i0r_ff;

   slmd_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(DELAY_DEPTH)) u_left (
      .clock(clock), .wr_en(cmd.write_line), .wr_addr(widx_ff), .wr_data(xl_ff),
      .rd_addr(ram_ra_l), .rd_data(rdl));
   slmd_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(DELAY_DEPTH)) u_right (
      .clock(clock), .wr_en(cmd.write_line), .wr_addr(widx_ff), .wr_data(xr_ff),
      .rd_addr(ram_ra_r), .rd_data(rdr));

   function automatic logic [AW:0] age(input logic [AW-1:0] w, input logic [AW-1:0] i);
      return {1'b0, AW'(w - i)};
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] mixf(
         input logic signed [SAMPLE_WIDTH-1:0] b0, input logic signed [SAMPLE_WIDTH-1:0] b1,
         input logic [7:0] f);
      logic signed [SAMPLE_WIDTH+10:0] acc;
      acc = b0 * $signed({1'b0, f}) + b1 * $signed({1'b0, 9'd256 - {1'b0, f}})
            + (SAMPLE_WIDTH+11)'(128);
      if (f == 8'd0) acc = (b1 <<< 8) + (SAMPLE_WIDTH+11)'(128);
      return SAMPLE_WIDTH'(acc >>> 8);
   endfunction

   logic signed [SAMPLE_WIDTH-1:0] rl0, rr0;
   assign rl0 = v0l_ff ? rdl : '0;
   assign rr0 = v0r_ff ? rdr : '0;

   assign out_left = ol_ff;
   assign out_right = or_ff;

   always_comb begin
      sm_in = sm_ff;
      fill_in = fill_ff;
      if (cmd.bypass_chk && tgt == 17'd0 && sm_ff <= EpsQ24) sm_in = '0;
      if (cmd.smooth) begin
         if (smn < 0) sm_in = '0;
         else if (smn > $signed({2'b0, FullQ24})) sm_in = FullQ24;
         else sm_in = smn[24:0];
      end
      if (cmd.write_line && fill_ff != (AW+1)'(DELAY_DEPTH)) fill_in = fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         widx_ff <= '0;
         lph_ff <= '0;
         rph_ff <= 32'h4000_0000;
         sm_ff <= '0;
         byp_ff <= 1'b0;
         rd_ph_ff <= '0;
      end else begin
         sm_ff <= sm_in;
         fill_ff <= fill_in;
         if (cmd.bypass_chk) begin
            byp_ff <= (tgt == 17'd0) && (sm_ff <= EpsQ24);
            xl_ff <= in_left;
            xr_ff <= in_right;
            ol_ff <= in_left;
            or_ff <= in_right;
         end
         if (cmd.smooth) begin
            ml_ff <= ml;
            mr_ff <= mr;
         end
         if (cmd.delay) begin
            dl_ff <= dln;
            dr_ff <= drn;
         end
         if (cmd.addr) begin
            i0l_ff <= widx_ff - dl_ff[DW-1:8] - 1'b1;
            i0r_ff <= widx_ff - dr_ff[DW-1:8] - 1'b1;
            v1l_ff <= age(widx_ff, AW'(widx_ff - dl_ff[DW-1:8])) < fill_ff;
            v1r_ff <= age(widx_ff, AW'(widx_ff - dr_ff[DW-1:8])) < fill_ff;
            v0l_ff <= age(widx_ff, AW'(widx_ff - dl_ff[DW-1:8] - 1'b1)) < fill_ff;
            v0r_ff <= age(widx_ff, AW'(widx_ff - dr_ff[DW-1:8] - 1'b1)) < fill_ff;
            gl_ff <= dl_ff[7:0];
            gr_ff <= dr_ff[7:0];
            rd_ph_ff <= 2'd1;
         end else if (rd_ph_ff == 2'd1) begin
            // first read data (newer sample) arrives now
            b1l_ff <= v1l_ff ? rdl : '0;
            b1r_ff <= v1r_ff ? rdr : '0;
            rd_ph_ff <= 2'd2;
         end else if (rd_ph_ff == 2'd2) begin
            rd_ph_ff <= 2'd0;
         end
         if (cmd.mix) begin
            ol_ff <= mixf(rl0, b1l_ff, gl_ff);
            or_ff <= mixf(rr0, b1r_ff, gr_ff);
         end
         if (cmd.commit && !byp_ff) begin
            lph_ff <= lph_ff + {12'b0, rate_left};
            rph_ff <= rph_ff + {12'b0, rate_right};
            widx_ff <= widx_ff + 1'b1;
         end
      end
   end
endmodule
